// ----- src/ffba_pkg.sv -----
// Shared constants and types of the first-fit block allocator.
package ffba_pkg;

    localparam int OFF_W        = 10;
    localparam int XW           = 11;
    localparam int RECIP_SHIFT  = 16;
    localparam int HEADER_BYTES = 16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

// ----- src/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ffba_div.sv -----
// Two-stage divider by the granule size: reciprocal multiply, then one correction step.
module ffba_div
    import ffba_pkg::*;
#(
    parameter int ALIGN_BYTES = 16
) (
    input  logic          i_clk,
    input  logic [XW-1:0] i_x,
    output logic [XW-1:0] o_quot,
    output logic [XW-1:0] o_rem
);

    localparam int RECIP = (1 << RECIP_SHIFT) / ALIGN_BYTES;
    localparam int PW    = XW + RECIP_SHIFT;

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_q0;
    logic [XW-1:0] r_quot;
    logic [XW-1:0] r_rem;
    logic [PW-1:0] w_prod;
    logic [XW-1:0] w_back;
    logic [XW-1:0] w_diff;

    assign w_prod = PW'(i_x) * PW'(RECIP);
    assign w_back = XW'(r_q0 * XW'(ALIGN_BYTES));
    assign w_diff = r_x - w_back;

    always_ff @(posedge i_clk) begin
        r_x  <= i_x;
        r_q0 <= w_prod[PW-1:RECIP_SHIFT];
        if (w_diff >= XW'(ALIGN_BYTES)) begin
            r_quot <= r_q0 + XW'(1);
            r_rem  <= w_diff - XW'(ALIGN_BYTES);
        end else begin
            r_quot <= r_q0;
            r_rem  <= w_diff;
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- src/first_fit_block_allocator.sv -----
// First-fit arena allocator with block splitting; block table held in one RAM.
//
// After reset the block writes the initial block table, one entry per granule,
// with the input stalled. An item then passes its setup steps: accept, then the two
// divider stages. An allocate then walks the block chain one block per cycle,
// because each RAM read supplies the size that locates the next header. The walk
// covers up to 63 blocks in the default arena, since a block may be a bare header.
// A split adds the ST_HEAD step to write back the header, and ST_DONE delivers the
// result once the output is free. The next item is accepted while a result still
// waits at the output.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int ARENA_BYTES     = 1024,
    parameter int ALIGN_BYTES     = 16,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_op,
    input  logic [OFF_W-1:0] i_request_bytes,
    input  logic [OFF_W-1:0] i_free_offset,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_granted,
    output logic [OFF_W-1:0] o_payload_offset
);

    localparam int GRANULES       = ARENA_BYTES / ALIGN_BYTES;
    localparam int HDR_GRAN       = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int MIN_SPLIT_GRAN = (MIN_SPLIT_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int AW             = $clog2(GRANULES);
    localparam int EW             = AW + 2;
    localparam int CW             = ((AW > XW) ? AW : XW) + 2;
    localparam int PW             = CW + $clog2(ALIGN_BYTES) + 1;

    typedef struct packed {
        logic          start;
        logic          used;
        logic [AW-1:0] size;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_START,
        ST_WALK,
        ST_HEAD,
        ST_FREE,
        ST_DONE
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [XW-1:0]    r_need;
    logic [AW-1:0]    r_g;
    logic [AW-1:0]    r_clr_idx;
    logic             r_res_grant;
    logic [OFF_W-1:0] r_res_poff;
    logic             r_out_valid;
    logic             r_granted;
    logic [OFF_W-1:0] r_poff;

    logic             w_accept;
    logic [XW-1:0]    w_x;
    logic [XW-1:0]    w_quot;
    logic [XW-1:0]    w_rem;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_rdata;
    t_entry           w_rd;
    logic [CW-1:0]    w_size_c;
    logic [CW-1:0]    w_need_c;
    logic [CW-1:0]    w_rest_c;
    logic [CW-1:0]    w_ns_c;
    logic [CW-1:0]    w_next_c;
    logic [CW-1:0]    w_free_g_c;
    logic [PW-1:0]    w_poff_full;
    logic             w_fit;
    logic             w_split;
    logic             w_more;
    logic             w_free_ok;
    logic             w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_x        = (t_op'(i_op) == OP_FREE) ? XW'(i_free_offset)
                                                 : XW'(i_request_bytes) + XW'(ALIGN_BYTES - 1);
    assign w_rd       = t_entry'(w_rdata);
    assign w_size_c   = CW'(w_rd.size);
    assign w_need_c   = CW'(r_need);
    assign w_rest_c   = w_size_c - w_need_c - CW'(HDR_GRAN);
    assign w_ns_c     = CW'(r_g) + CW'(HDR_GRAN) + w_need_c;
    assign w_next_c   = CW'(r_g) + CW'(HDR_GRAN) + w_size_c;
    assign w_fit      = w_rd.start && !w_rd.used && (w_size_c >= w_need_c);
    assign w_split    = (w_size_c >= w_need_c + CW'(HDR_GRAN))
                        && (w_rest_c >= CW'(MIN_SPLIT_GRAN))
                        && (w_ns_c < CW'(GRANULES));
    assign w_more     = w_rd.start && (w_next_c < CW'(GRANULES));
    assign w_free_g_c = CW'(w_quot) - CW'(HDR_GRAN);
    assign w_free_ok  = (w_rem == '0) && (CW'(w_quot) >= CW'(HDR_GRAN))
                        && (w_free_g_c < CW'(GRANULES));
    assign w_poff_full = PW'(CW'(r_g) + CW'(HDR_GRAN)) * PW'(ALIGN_BYTES);
    assign w_out_free = !r_out_valid || !i_out_stall;

    ffba_div #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_div (
        .i_clk (i_clk),
        .i_x   (w_x),
        .o_quot(w_quot),
        .o_rem (w_rem)
    );

    ffba_ram #(
        .WIDTH(EW),
        .DEPTH(GRANULES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_raddr = r_g;
        unique case (r_state)
            ST_START: begin
                w_raddr = (r_op == OP_FREE) ? w_free_g_c[AW-1:0] : '0;
            end
            ST_WALK: begin
                w_raddr = w_next_c[AW-1:0];
            end
            default: begin
                w_raddr = r_g;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_g;
        w_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_idx;
                if (r_clr_idx == '0) begin
                    w_wdata = '{start: 1'b1, used: 1'b0, size: AW'(GRANULES - HDR_GRAN)};
                end
            end
            ST_WALK: begin
                if (w_fit && w_split) begin
                    w_we    = 1'b1;
                    w_waddr = w_ns_c[AW-1:0];
                    w_wdata = '{start: 1'b1, used: 1'b0, size: w_rest_c[AW-1:0]};
                end else if (w_fit) begin
                    w_we    = 1'b1;
                    w_wdata = '{start: 1'b1, used: 1'b1, size: w_rd.size};
                end
            end
            ST_HEAD: begin
                w_we    = 1'b1;
                w_wdata = '{start: 1'b1, used: 1'b1, size: r_need[AW-1:0]};
            end
            ST_FREE: begin
                if (w_rd.start) begin
                    w_we    = 1'b1;
                    w_wdata = '{start: 1'b1, used: 1'b0, size: w_rd.size};
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == AW'(GRANULES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_op'(i_op);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_need      <= w_quot;
                    r_res_grant <= 1'b0;
                    r_res_poff  <= '0;
                    if (r_op == OP_ALLOC) begin
                        r_g     <= '0;
                        r_state <= ST_WALK;
                    end else if (w_free_ok) begin
                        r_g     <= w_free_g_c[AW-1:0];
                        r_state <= ST_FREE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_WALK: begin
                    if (w_fit) begin
                        r_res_grant <= 1'b1;
                        r_res_poff  <= w_poff_full[OFF_W-1:0];
                        r_state     <= w_split ? ST_HEAD : ST_DONE;
                    end else if (w_more) begin
                        r_g <= w_next_c[AW-1:0];
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_HEAD: begin
                    r_state <= ST_DONE;
                end
                ST_FREE: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_granted <= r_res_grant;
                        r_poff    <= r_res_poff;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_payload_offset = r_poff;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !w_we)
        else $error("block table written outside an operation");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> (w_rem < XW'(ALIGN_BYTES)))
        else $error("divider remainder out of range");

    a_free_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_op == OP_FREE) |-> !r_res_grant)
        else $error("free produced a grant");

    a_walk_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> w_rd.start)
        else $error("walk reached a granule that starts no block");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_payload_offset == '0))
        else $error("nonzero offset without grant");
`endif

endmodule
